[rtl/assert_macros.svh]
// Assertion macros used by the cache controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is held
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/arpc_pkg.sv]
// Types, constants and codes for the ARP cache and forwarding decision block
package arpc_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int NUM_INTERFACES = 3;
  localparam int PREFIX_BYTES   = 3;
  localparam int IF_SLOTS       = 3;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int ENTRY_W = IP_W + MAC_W;
  localparam int ACT_W   = 3;
  localparam int ITF_W   = 2;
  localparam int CNT_IF_W = 2;
  localparam int REG_W   = 3;
  localparam int ADDR_W  = REG_W + 3;
  localparam int DATA_W  = 64;

  localparam logic [IP_W-1:0] PREFIX_MASK =
    IP_W'({IP_W{1'b1}} << (8 * (4 - PREFIX_BYTES)));

  typedef enum logic [ACT_W-1:0] {
    ACT_LEARNED       = 3'd0,
    ACT_FULL          = 3'd1,
    ACT_NO_ROUTE      = 3'd2,
    ACT_BCAST_LEARNED = 3'd3,
    ACT_BCAST_DROP    = 3'd4,
    ACT_LOOPBACK      = 3'd5,
    ACT_FORWARD       = 3'd6,
    ACT_ARP_REQUEST   = 3'd7
  } action_t;

  typedef enum logic {
    KIND_LEARN   = 1'b0,
    KIND_FORWARD = 1'b1
  } kind_t;

  typedef enum logic [REG_W-1:0] {
    REG_IF0_IP   = 3'd0,
    REG_IF0_MAC  = 3'd1,
    REG_IF1_IP   = 3'd2,
    REG_IF1_MAC  = 3'd3,
    REG_IF2_IP   = 3'd4,
    REG_IF2_MAC  = 3'd5,
    REG_IF_COUNT = 3'd6,
    REG_LB_MASK  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [IF_SLOTS-1:0][IP_W-1:0]  if_ip;
    logic [IF_SLOTS-1:0][MAC_W-1:0] if_mac;
    logic [CNT_IF_W-1:0]            if_count;
    logic [IF_SLOTS-1:0]            lb_mask;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

[rtl/arpc_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data
module arpc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 80,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/arpc_cfg.sv]
// APB register bank: interface addresses, interface count and loopback mask
module arpc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::DATA_W-1:0]  pwdata,
  output logic [arpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output arpc_pkg::cfg_t               cfg
);
  import arpc_pkg::*;

  logic [IF_SLOTS-1:0][IP_W-1:0]  if_ip_r;
  logic [IF_SLOTS-1:0][MAC_W-1:0] if_mac_r;
  logic [CNT_IF_W-1:0]            if_count_r;
  logic [IF_SLOTS-1:0]            lb_mask_r;
  logic                           wr_en;
  reg_idx_t                       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if_ip_r    <= '0;
      if_mac_r   <= '0;
      if_count_r <= '0;
      lb_mask_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_IF0_IP:   if_ip_r[0]  <= pwdata[IP_W-1:0];
        REG_IF0_MAC:  if_mac_r[0] <= pwdata[MAC_W-1:0];
        REG_IF1_IP:   if_ip_r[1]  <= pwdata[IP_W-1:0];
        REG_IF1_MAC:  if_mac_r[1] <= pwdata[MAC_W-1:0];
        REG_IF2_IP:   if_ip_r[2]  <= pwdata[IP_W-1:0];
        REG_IF2_MAC:  if_mac_r[2] <= pwdata[MAC_W-1:0];
        REG_IF_COUNT: if_count_r  <= pwdata[CNT_IF_W-1:0];
        REG_LB_MASK:  lb_mask_r   <= pwdata[IF_SLOTS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_IF0_IP:   prdata = DATA_W'(if_ip_r[0]);
      REG_IF0_MAC:  prdata = DATA_W'(if_mac_r[0]);
      REG_IF1_IP:   prdata = DATA_W'(if_ip_r[1]);
      REG_IF1_MAC:  prdata = DATA_W'(if_mac_r[1]);
      REG_IF2_IP:   prdata = DATA_W'(if_ip_r[2]);
      REG_IF2_MAC:  prdata = DATA_W'(if_mac_r[2]);
      REG_IF_COUNT: prdata = DATA_W'(if_count_r);
      REG_LB_MASK:  prdata = DATA_W'(lb_mask_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.if_ip    = if_ip_r;
  assign cfg.if_mac   = if_mac_r;
  assign cfg.if_count = if_count_r;
  assign cfg.lb_mask  = lb_mask_r;

endmodule

[rtl/arpc_ctrl.sv]
// Sequencer: route decision, table scan through the RAM, write-back and result register
module arpc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [arpc_pkg::IP_W-1:0]    in_dst_ip,
  input  logic [arpc_pkg::IP_W-1:0]    in_src_ip,
  input  logic [arpc_pkg::MAC_W-1:0]   in_src_mac,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [arpc_pkg::ACT_W-1:0]   out_action,
  output logic [arpc_pkg::ITF_W-1:0]   out_out_interface,
  output logic [arpc_pkg::MAC_W-1:0]   out_next_hop_mac,
  output logic [arpc_pkg::MAC_W-1:0]   out_egress_mac,
  output logic [arpc_pkg::IP_W-1:0]    out_target_ip,
  output logic [arpc_pkg::IP_W-1:0]    out_sender_ip,
  input  arpc_pkg::cfg_t               cfg,
  output arpc_pkg::ram_req_t           ram_req,
  input  logic [arpc_pkg::ENTRY_W-1:0] ram_rdata
);
  import arpc_pkg::*;

  state_t st_r, st_nxt;

  // accepted beat
  kind_t             kind_r;
  logic [IP_W-1:0]   dst_r;
  logic [IP_W-1:0]   sip_r;
  logic [MAC_W-1:0]  smac_r;

  // decision
  logic [IP_W-1:0]   key_r;
  logic              learn_r;
  action_t           act_r;
  logic [ITF_W-1:0]  itf_r;

  // scan
  logic [CNT_W-1:0]  cnt_r;
  logic              cmp_v_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [MAC_W-1:0]  hit_mac_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // result register
  logic              out_valid_r;
  action_t           o_act_r;
  logic [ITF_W-1:0]  o_itf_r;
  logic [MAC_W-1:0]  o_nh_r;
  logic [MAC_W-1:0]  o_eg_r;
  logic [IP_W-1:0]   o_tgt_r;
  logic [IP_W-1:0]   o_snd_r;

  logic              accept;
  logic [CNT_IF_W-1:0] cnt_lim;
  logic              if_found;
  logic [ITF_W-1:0]  if_sel;
  logic              dec_scan;
  logic              dec_learn;
  action_t           dec_act;
  logic [IP_W-1:0]   dec_key;
  logic              issue;
  logic              ent_match;
  logic              ent_free;
  logic              cmp_last;
  logic              out_free;
  logic              load;
  action_t           res_act;
  logic [ITF_W-1:0]  res_itf;
  logic [MAC_W-1:0]  res_nh;
  logic [MAC_W-1:0]  res_eg;
  logic [IP_W-1:0]   res_tgt;
  logic [IP_W-1:0]   res_snd;

  assign accept = in_valid && in_ready;

  // interface match, lowest index first
  assign cnt_lim = (cfg.if_count > CNT_IF_W'(NUM_INTERFACES)) ?
                   CNT_IF_W'(NUM_INTERFACES) : cfg.if_count;

  always_comb begin
    if_found = 1'b0;
    if_sel   = '0;
    for (int i = 0; i < NUM_INTERFACES; i++) begin
      if (!if_found && (CNT_IF_W'(i) < cnt_lim) &&
          (((cfg.if_ip[i] ^ dst_r) & PREFIX_MASK) == '0)) begin
        if_found = 1'b1;
        if_sel   = ITF_W'(i);
      end
    end
  end

  always_comb begin
    dec_scan  = 1'b0;
    dec_learn = 1'b0;
    dec_act   = ACT_NO_ROUTE;
    dec_key   = dst_r;
    priority if (kind_r == KIND_LEARN) begin
      dec_scan  = 1'b1;
      dec_learn = 1'b1;
      dec_act   = ACT_LEARNED;
      dec_key   = sip_r;
    end else if (!if_found) begin
      if (dst_r == {IP_W{1'b1}}) begin
        dec_scan  = 1'b1;
        dec_learn = 1'b1;
        dec_act   = ACT_BCAST_LEARNED;
        dec_key   = sip_r;
      end else begin
        dec_act = ACT_NO_ROUTE;
      end
    end else if (dst_r[7:0] == 8'hFF) begin
      dec_act = ACT_BCAST_DROP;
    end else if (cfg.lb_mask[if_sel]) begin
      dec_act = ACT_LOOPBACK;
    end else begin
      dec_scan = 1'b1;
      dec_act  = ACT_FORWARD;
    end
  end

  // scan pipeline: address now, entry data next cycle
  assign issue     = (cnt_r < CNT_W'(TABLE_DEPTH));
  assign ent_match = cmp_v_r && valid_r[cmp_idx_r] &&
                     (ram_rdata[ENTRY_W-1:MAC_W] == key_r);
  assign ent_free  = cmp_v_r && !valid_r[cmp_idx_r];
  assign cmp_last  = cmp_v_r && (cmp_idx_r == IDX_W'(TABLE_DEPTH - 1));

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (accept) st_nxt = ST_DECIDE;
      ST_DECIDE: st_nxt = dec_scan ? ST_SCAN : ST_FINISH;
      ST_SCAN:   if (cmp_last) st_nxt = ST_FINISH;
      ST_FINISH: if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready      = 1'b0;
    load          = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.raddr = cnt_r[IDX_W-1:0];
    ram_req.we    = 1'b0;
    ram_req.waddr = hit_r ? hit_idx_r : free_idx_r;
    ram_req.wdata = {sip_r, smac_r};
    unique case (st_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_DECIDE: ;
      ST_SCAN:   ram_req.re = issue;
      ST_FINISH: begin
        load       = out_free;
        ram_req.we = out_free && learn_r && (hit_r || free_r);
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res_act = act_r;
    if (learn_r) begin
      res_act = (hit_r || free_r) ? act_r : ACT_FULL;
    end else if (act_r == ACT_FORWARD) begin
      res_act = hit_r ? ACT_FORWARD : ACT_ARP_REQUEST;
    end
    res_itf = '0;
    res_nh  = '0;
    res_eg  = '0;
    res_tgt = '0;
    res_snd = '0;
    unique case (res_act)
      ACT_LOOPBACK: res_itf = itf_r;
      ACT_FORWARD: begin
        res_itf = itf_r;
        res_nh  = hit_mac_r;
        res_eg  = cfg.if_mac[itf_r];
      end
      ACT_ARP_REQUEST: begin
        res_itf = itf_r;
        res_nh  = {MAC_W{1'b1}};
        res_eg  = cfg.if_mac[itf_r];
        res_tgt = dst_r;
        res_snd = cfg.if_ip[itf_r];
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cmp_v_r <= (st_r == ST_SCAN) && issue;
      if (ram_req.we && !hit_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      dst_r  <= in_dst_ip;
      sip_r  <= in_src_ip;
      smac_r <= in_src_mac;
    end
    if (st_r == ST_DECIDE) begin
      key_r   <= dec_key;
      learn_r <= dec_learn;
      act_r   <= dec_act;
      itf_r   <= if_sel;
      cnt_r   <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else if (st_r == ST_SCAN) begin
      if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (ent_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
        hit_mac_r <= ram_rdata[MAC_W-1:0];
      end
      if (ent_free && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
    cmp_idx_r <= cnt_r[IDX_W-1:0];
    if (load) begin
      o_act_r <= res_act;
      o_itf_r <= res_itf;
      o_nh_r  <= res_nh;
      o_eg_r  <= res_eg;
      o_tgt_r <= res_tgt;
      o_snd_r <= res_snd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = o_act_r;
  assign out_out_interface = o_itf_r;
  assign out_next_hop_mac  = o_nh_r;
  assign out_egress_mac    = o_eg_r;
  assign out_target_ip     = o_tgt_r;
  assign out_sender_ip     = o_snd_r;

`include "assert_macros.svh"

  `ARPC_ASSERT_NEXT(a_fill_grows, 1'b1, $countones(valid_r) >= $countones($past(valid_r)), "cache entries lost")
  `ARPC_ASSERT_NOW(a_new_slot_free, ram_req.we && !hit_r, !valid_r[free_idx_r], "new pair overwrote a live entry")
  `ARPC_ASSERT_NEXT(a_scan_ends, (st_r == ST_SCAN) && cmp_last, st_r == ST_FINISH, "scan overran last entry")

endmodule

[rtl/arp_cache_forward_decision.sv]
// One item is taken at a time: the block takes the beat, matches the destination against
// the interfaces, walks the table entry by entry through the RAM's single read port,
// comparing each entry once its registered read data returns, and then writes back and
// loads the result register. Items that need no table lookup (no route, broadcast drop,
// loopback) skip the scan. The result register lets the next beat in while a result still
// waits. Entry valid bits are flip-flops cleared by reset, so no clearing pass follows
// reset. All configuration registers reset to zero and sit at byte address 8 * index,
// 64-bit data.
module arp_cache_forward_decision (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [arpc_pkg::IP_W-1:0]    in_dst_ip,
  input  logic [arpc_pkg::IP_W-1:0]    in_src_ip,
  input  logic [arpc_pkg::MAC_W-1:0]   in_src_mac,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [arpc_pkg::ACT_W-1:0]   out_action,
  output logic [arpc_pkg::ITF_W-1:0]   out_out_interface,
  output logic [arpc_pkg::MAC_W-1:0]   out_next_hop_mac,
  output logic [arpc_pkg::MAC_W-1:0]   out_egress_mac,
  output logic [arpc_pkg::IP_W-1:0]    out_target_ip,
  output logic [arpc_pkg::IP_W-1:0]    out_sender_ip,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::DATA_W-1:0]  pwdata,
  output logic [arpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import arpc_pkg::*;

  cfg_t               cfg;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;

  arpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arpc_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  arpc_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_dst_ip         (in_dst_ip),
    .in_src_ip         (in_src_ip),
    .in_src_mac        (in_src_mac),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_out_interface (out_out_interface),
    .out_next_hop_mac  (out_next_hop_mac),
    .out_egress_mac    (out_egress_mac),
    .out_target_ip     (out_target_ip),
    .out_sender_ip     (out_sender_ip),
    .cfg               (cfg),
    .ram_req           (ram_req),
    .ram_rdata         (ram_rdata)
  );

endmodule

[verif/arp_cache_forward_decision_tb.sv]
// Self-checking testbench for the ARP cache and forwarding decision block
`timescale 1ns / 100ps

module arp_cache_forward_decision_tb;
  import arpc_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    kind_t             kind;
    logic [IP_W-1:0]   dst;
    logic [IP_W-1:0]   src;
    logic [MAC_W-1:0]  mac;
  } packet_t;

  typedef struct packed {
    action_t           action;
    logic [ITF_W-1:0]  itf;
    logic [MAC_W-1:0]  nh_mac;
    logic [MAC_W-1:0]  eg_mac;
    logic [IP_W-1:0]   tgt_ip;
    logic [IP_W-1:0]   snd_ip;
  } decision_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic                in_kind    = 1'b0;
  logic [IP_W-1:0]     in_dst_ip  = '0;
  logic [IP_W-1:0]     in_src_ip  = '0;
  logic [MAC_W-1:0]    in_src_mac = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [ACT_W-1:0]    out_action;
  logic [ITF_W-1:0]    out_out_interface;
  logic [MAC_W-1:0]    out_next_hop_mac;
  logic [MAC_W-1:0]    out_egress_mac;
  logic [IP_W-1:0]     out_target_ip;
  logic [IP_W-1:0]     out_sender_ip;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]   pwdata     = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state: interface settings and the cache table
  bit [IP_W-1:0]       if_ip_cfg [IF_SLOTS];
  bit [MAC_W-1:0]      if_mac_cfg [IF_SLOTS];
  bit [CNT_IF_W-1:0]   if_count_cfg;
  bit [IF_SLOTS-1:0]   lb_mask_cfg;
  bit                  tbl_valid [TABLE_DEPTH];
  bit [IP_W-1:0]       tbl_ip [TABLE_DEPTH];
  bit [MAC_W-1:0]      tbl_mac [TABLE_DEPTH];

  packet_t             packet_queue [$];
  decision_t           expected_decisions [$];
  logic [IP_W-1:0]     ip_pool [POOL_SIZE];
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  rx_hold        = 1'b0;
  int                  mismatches     = 0;
  int                  cycle_count    = 0;

  arp_cache_forward_decision dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_dst_ip         (in_dst_ip),
    .in_src_ip         (in_src_ip),
    .in_src_mac        (in_src_mac),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_out_interface (out_out_interface),
    .out_next_hop_mac  (out_next_hop_mac),
    .out_egress_mac    (out_egress_mac),
    .out_target_ip     (out_target_ip),
    .out_sender_ip     (out_sender_ip),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  function automatic int find_entry(logic [IP_W-1:0] ip);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  // insert or refresh a pair; 0 when the table has no free slot
  function automatic bit store_pair(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    int slot;
    slot = find_entry(ip);
    if (slot < 0) begin
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) slot = i;
      end
    end
    if (slot < 0) return 1'b0;
    tbl_valid[slot] = 1'b1;
    tbl_ip[slot]    = ip;
    tbl_mac[slot]   = mac;
    return 1'b1;
  endfunction

  function automatic decision_t decide_packet(logic kind, logic [IP_W-1:0] dst,
                                              logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac);
    decision_t d;
    int        itf;
    int        hit;
    int        count;
    d = '0;
    if (kind == KIND_LEARN) begin
      d.action = store_pair(sip, smac) ? ACT_LEARNED : ACT_FULL;
      return d;
    end
    count = (if_count_cfg > NUM_INTERFACES) ? NUM_INTERFACES : if_count_cfg;
    itf = -1;
    // walk downwards so the lowest matching interface wins
    for (int i = count - 1; i >= 0; i--) begin
      if (((if_ip_cfg[i] ^ dst) & PREFIX_MASK) == '0) itf = i;
    end
    if (itf < 0) begin
      if (dst == '1) d.action = store_pair(sip, smac) ? ACT_BCAST_LEARNED : ACT_FULL;
      else d.action = ACT_NO_ROUTE;
      return d;
    end
    if (dst[7:0] == 8'hFF) begin
      d.action = ACT_BCAST_DROP;
      return d;
    end
    d.itf = itf[ITF_W-1:0];
    if (lb_mask_cfg[itf]) begin
      d.action = ACT_LOOPBACK;
      return d;
    end
    hit = find_entry(dst);
    d.eg_mac = if_mac_cfg[itf];
    if (hit >= 0) begin
      d.action = ACT_FORWARD;
      d.nh_mac = tbl_mac[hit];
    end else begin
      d.action = ACT_ARP_REQUEST;
      d.nh_mac = '1;
      d.tgt_ip = dst;
      d.snd_ip = if_ip_cfg[itf];
    end
    return d;
  endfunction

  function automatic packet_t mk_packet(kind_t k, logic [IP_W-1:0] d, logic [IP_W-1:0] s,
                                        logic [MAC_W-1:0] m);
    packet_t p;
    p.kind = k;
    p.dst  = d;
    p.src  = s;
    p.mac  = m;
    return p;
  endfunction

  // mostly pool addresses and interface subnets so lookups hit; a tenth is pure noise
  function automatic packet_t rand_packet();
    packet_t p;
    int      pick;
    p.kind = ($urandom_range(0, 99) < 30) ? KIND_LEARN : KIND_FORWARD;
    p.dst  = $urandom();
    p.src  = $urandom();
    p.mac  = MAC_W'({$urandom(), $urandom()});
    pick   = $urandom_range(0, 99);
    if (pick < 10) return p;
    if (p.kind == KIND_LEARN) begin
      if (pick < 75) p.src = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 50) begin
      p.dst = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 75) begin
      p.dst = {if_ip_cfg[$urandom_range(0, IF_SLOTS - 1)][IP_W-1:8],
               ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom())};
    end else if (pick < 85) begin
      p.dst = '1;
      p.src = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IF0_IP:   if_ip_cfg[0]  = val[IP_W-1:0];
      REG_IF0_MAC:  if_mac_cfg[0] = val[MAC_W-1:0];
      REG_IF1_IP:   if_ip_cfg[1]  = val[IP_W-1:0];
      REG_IF1_MAC:  if_mac_cfg[1] = val[MAC_W-1:0];
      REG_IF2_IP:   if_ip_cfg[2]  = val[IP_W-1:0];
      REG_IF2_MAC:  if_mac_cfg[2] = val[MAC_W-1:0];
      REG_IF_COUNT: if_count_cfg  = val[CNT_IF_W-1:0];
      REG_LB_MASK:  lb_mask_cfg   = val[IF_SLOTS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] ip0, logic [47:0] mac0, logic [31:0] ip1,
                            logic [47:0] mac1, logic [31:0] ip2, logic [47:0] mac2,
                            logic [1:0] count, logic [2:0] lb);
    write_reg(REG_IF0_IP, 64'(ip0));
    write_reg(REG_IF0_MAC, 64'(mac0));
    write_reg(REG_IF1_IP, 64'(ip1));
    write_reg(REG_IF1_MAC, 64'(mac1));
    write_reg(REG_IF2_IP, 64'(ip2));
    write_reg(REG_IF2_MAC, 64'(mac2));
    write_reg(REG_IF_COUNT, 64'(count));
    write_reg(REG_LB_MASK, 64'(lb));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (packet_queue.size() != 0 || in_valid || expected_decisions.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(int n, int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) packet_queue.push_back(rand_packet());
    wait_idle();
  endtask

  always @(posedge clk) begin : packet_driver
    packet_t pkt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_decisions.push_back(decide_packet(in_kind, in_dst_ip, in_src_ip, in_src_mac));
      if (!in_valid || in_ready) begin
        if (packet_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pkt = packet_queue.pop_front();
          in_valid   <= 1'b1;
          in_kind    <= pkt.kind;
          in_dst_ip  <= pkt.dst;
          in_src_ip  <= pkt.src;
          in_src_mac <= pkt.mac;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : decision_monitor
    decision_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("beat with nothing outstanding", 64'(out_action), 64'(0));
        end else begin
          want = expected_decisions.pop_front();
          if (out_action !== want.action)
            report_mismatch("action", 64'(out_action), 64'(want.action));
          if (out_out_interface !== want.itf)
            report_mismatch("out_interface", 64'(out_out_interface), 64'(want.itf));
          if (out_next_hop_mac !== want.nh_mac)
            report_mismatch("next_hop_mac", 64'(out_next_hop_mac), 64'(want.nh_mac));
          if (out_egress_mac !== want.eg_mac)
            report_mismatch("egress_mac", 64'(out_egress_mac), 64'(want.eg_mac));
          if (out_target_ip !== want.tgt_ip)
            report_mismatch("target_ip", 64'(out_target_ip), 64'(want.tgt_ip));
          if (out_sender_ip !== want.snd_ip)
            report_mismatch("sender_ip", 64'(out_sender_ip), 64'(want.snd_ip));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 3)
        0:       ip_pool[i] = {24'h0A0000, 8'(10 + i)};
        1:       ip_pool[i] = {24'hC0A801, 8'(10 + i)};
        default: ip_pool[i] = {24'hAC1005, 8'(10 + i)};
      endcase
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no interfaces, so no forward matches an interface
    @(negedge clk);
    packet_queue.push_back(mk_packet(KIND_LEARN, 32'h0808_0808, 32'h0A00_0005, 48'h0200_0000_0005));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'h0808_0808, 32'h0A00_0005, 48'h1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'hFFFF_FFFF, 32'hC0A8_0107, '1));
    packet_queue.push_back(mk_packet(KIND_LEARN, 32'hFFFF_FFFF, 32'h0, 48'h0));
    wait_idle();

    set_config(32'h0A00_0001, 48'h00AA_0000_0001, 32'hC0A8_0101, 48'h00BB_0000_0002,
               32'hAC10_0501, 48'h00CC_0000_0003, 2'd3, 3'b100);
    @(negedge clk);
    packet_queue.push_back(mk_packet(KIND_LEARN, 32'h0, 32'h0A00_0005, 48'h0200_0000_0055));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'h0A00_0005, 32'h1, 48'h1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'h0A00_0006, 32'h1, 48'h1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'h0A00_00FF, 32'h1, 48'h1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'hAC10_0509, 32'h1, 48'h1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'hC0A8_0107, 32'h1, 48'h1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'hFFFF_FFFF, 32'hC0A8_0108, 48'h3));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'h0, '1, '1));
    packet_queue.push_back(mk_packet(KIND_LEARN, 32'h0, '1, '1));
    packet_queue.push_back(mk_packet(KIND_FORWARD, 32'hC0A8_0100, 32'h0, 48'h0));
    wait_idle();

    set_config(32'h0A00_0001, 48'h00AA_0000_0001, 32'hC0A8_0101, 48'h00BB_0000_0002,
               32'hAC10_0501, 48'h00CC_0000_0003, 2'd3, 3'b000);
    run_random(150, 0, 0);

    set_config(32'hC0A8_0164, 48'h1234_5678_9ABC, 32'h0A00_0001, 48'h0F0F_0F0F_0F0F,
               32'hAC10_0501, 48'hF0F0_F0F0_F0F0, 2'd2, 3'b001);
    run_random(150, 53, 0);

    set_config(32'hAC10_05FE, 48'h5555_5555_5555, 32'h0A00_0001, 48'hAAAA_AAAA_AAAA,
               32'hC0A8_0101, 48'h0000_0000_0001, 2'd1, 3'b111);
    run_random(120, 0, 53);

    // two interfaces on one subnet: the lower index must win
    set_config(32'h0A00_0001, 48'h00AA_0000_0001, 32'h0A00_00FE, 48'h00AA_0000_00FE,
               32'hC0A8_0101, 48'h00BB_0000_0002, 2'd3, 3'b010);
    run_random(150, 29, 29);

    // extremes; receiver held off so the block backs up and stalls its input
    set_config(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000, 48'h0000_0000_0000,
               32'h0A00_0001, 48'h8000_0000_0001, 2'd3, 3'b000);
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (100) packet_queue.push_back(rand_packet());
    wait_idle();
    run_random(100, 0, 0);

    set_config(32'h0A00_0001, 48'h00AA_0000_0001, 32'hC0A8_0101, 48'h00BB_0000_0002,
               32'hAC10_0501, 48'h00CC_0000_0003, 2'd0, 3'b111);
    run_random(60, 29, 29);

    set_config(32'hAC10_0501, 48'h00CC_0000_0003, 32'hC0A8_0101, 48'h00BB_0000_0002,
               32'h0A00_0001, 48'h00AA_0000_0001, 2'd3, 3'b000);
    run_random(100, 29, 29);

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_cfg.sv
rtl/arpc_ctrl.sv
rtl/arp_cache_forward_decision.sv
verif/arp_cache_forward_decision_tb.sv
